// ===== rtl/sara_pkg.sv =====
// ============================================================================
// sara_pkg: shared types and constants of the shelf atlas allocator
// Request and result layouts, operation and status codes, register indexes.
// ============================================================================
`default_nettype none

package sara_pkg;

    localparam int DIM_W      = 13;
    localparam int COORD_BITS = 12;
    localparam int HANDLE_W   = 10;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 3;

    localparam int S_TDATA_W  = 40;
    localparam int S_TUSER_W  = FUNC_W;
    localparam int M_TDATA_W  = 40;
    localparam int M_TUSER_W  = STATUS_W;
    localparam int CFG_IDX_W  = 1;

    localparam logic [DIM_W-1:0] DIM_DEFAULT = 13'd64;
    localparam logic [DIM_W-1:0] DIM_MAX     = 13'd4096;

    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_HEIGHT = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_ADD    = 2'd0,
        FN_REMOVE = 2'd1,
        FN_CLEAR  = 2'd2
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_PLACED     = 3'd0,
        ST_NO_SPACE   = 3'd1,
        ST_REMOVED    = 3'd2,
        ST_BAD_HANDLE = 3'd3,
        ST_CLEARED    = 3'd4,
        ST_FULL       = 3'd5
    } status_t;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [DIM_W-1:0]    rect_width;
        logic [DIM_W-1:0]    rect_height;
        logic [HANDLE_W-1:0] handle_in;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [HANDLE_W-1:0]   handle_out;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/sara_ram.sv =====
// ============================================================================
// sara_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ============================================================================
`default_nettype none

module sara_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/sara_core.sv =====
// ============================================================================
// sara_core: allocator sequencer
// Walks shelves and span lists held in three RAMs and updates them in place.
// ============================================================================
`default_nettype none

module sara_core #(
    parameter int MAX_SHELVES = 64,
    parameter int MAX_SPANS   = 1024,
    parameter int MAX_ITEMS   = 1024
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire sara_pkg::req_t              req,
    input  wire logic [sara_pkg::DIM_W-1:0]  atlas_w,
    input  wire logic [sara_pkg::DIM_W-1:0]  atlas_h,
    output logic                             res_valid,
    input  wire logic                        res_ready,
    output sara_pkg::res_t                   res
);

    localparam int DW  = sara_pkg::DIM_W;
    localparam int TW  = DW + 1;
    localparam int SHA = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
    localparam int SHC = $clog2(MAX_SHELVES + 1);
    localparam int SA  = (MAX_SPANS > 1) ? $clog2(MAX_SPANS) : 1;
    localparam int SPW = $clog2(MAX_SPANS + 1);
    localparam int IA  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int IPW = $clog2(MAX_ITEMS + 1);

    localparam int SHELF_W = 2 * DW + SPW;
    localparam int SPAN_W  = 2 * DW + SPW;
    localparam int ITEM_W  = 2 * DW + SHA + 1 + IPW;

    localparam logic [SPW-1:0] SNIL    = SPW'(MAX_SPANS);
    localparam logic [IPW-1:0] INIL    = IPW'(MAX_ITEMS);
    localparam logic [SHC-1:0] SH_FULL = SHC'(MAX_SHELVES);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_SH_RD, S_SH_CHK, S_WK_RD, S_WK_CHK, S_WK_END,
        S_SCAN_END, S_NEW_CHK, S_TAKE_RD, S_TAKE_DONE, S_NEW_WR, S_PLACE,
        S_PL_PUT, S_ITEM_TAKE, S_ITEM_NEXT, S_ITEM_WR, S_RM_ITEM, S_RM_SHRD,
        S_RM_SH, S_RM_WK_RD, S_RM_WK_CHK, S_RM_MERGE, S_RM_PUT, S_RM_NEW_WR,
        S_RM_LINK, S_RM_ITEM_WR, S_EMIT
    } state_t;

    state_t state_reg;

    logic [sara_pkg::FUNC_W-1:0]   func_reg;
    logic [DW-1:0]                 w_reg;
    logic [DW-1:0]                 h_reg;
    logic [sara_pkg::HANDLE_W-1:0] hd_reg;

    logic [SHC-1:0] shelf_count_reg;
    logic [SPW-1:0] span_free_head_reg;
    logic [SPW-1:0] span_used_reg;
    logic [IPW-1:0] item_free_head_reg;
    logic [IPW-1:0] item_used_reg;

    logic [SHC-1:0] s_idx_reg;
    logic [TW-1:0]  top_max_reg;
    logic           place_mode_reg;
    logic           best_valid_reg;
    logic [DW-1:0]  best_score_reg;
    logic [SHC-1:0] best_s_reg;
    logic           found_reg;

    logic [DW-1:0]  sh_top_reg;
    logic [DW-1:0]  sh_h_reg;
    logic [SHA-1:0] is_reg;
    logic [SPW-1:0] cur_reg;
    logic [SPW-1:0] prev_reg;
    logic [DW-1:0]  cur_x_reg;
    logic [DW-1:0]  cur_w_reg;
    logic [SPW-1:0] cur_next_reg;
    logic [DW-1:0]  prev_x_reg;
    logic [DW-1:0]  prev_w_reg;
    logic [SPW-1:0] prev_next_reg;
    logic [SPW-1:0] new_sp_reg;
    logic [IA-1:0]  it_idx_reg;
    logic [DW-1:0]  ix_reg;
    logic [DW-1:0]  place_top_reg;
    sara_pkg::res_t res_reg;

    // RAM ports
    logic               sh_we, sp_we, it_we;
    logic [SHA-1:0]     sh_waddr, sh_raddr;
    logic [SA-1:0]      sp_waddr, sp_raddr;
    logic [IA-1:0]      it_waddr, it_raddr;
    logic [SHELF_W-1:0] sh_wdata, sh_rdata;
    logic [SPAN_W-1:0]  sp_wdata, sp_rdata;
    logic [ITEM_W-1:0]  it_wdata, it_rdata;

    sara_ram #(.WIDTH(SHELF_W), .DEPTH(MAX_SHELVES)) u_shelf_ram (
        .clk(aclk), .we(sh_we), .waddr(sh_waddr), .wdata(sh_wdata),
        .raddr(sh_raddr), .rdata(sh_rdata)
    );

    sara_ram #(.WIDTH(SPAN_W), .DEPTH(MAX_SPANS)) u_span_ram (
        .clk(aclk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
        .raddr(sp_raddr), .rdata(sp_rdata)
    );

    sara_ram #(.WIDTH(ITEM_W), .DEPTH(MAX_ITEMS)) u_item_ram (
        .clk(aclk), .we(it_we), .waddr(it_waddr), .wdata(it_wdata),
        .raddr(it_raddr), .rdata(it_rdata)
    );

    // Read data fields
    logic [DW-1:0]  rd_sh_top, rd_sh_h, rd_sp_x, rd_sp_w, rd_it_x, rd_it_w;
    logic [SPW-1:0] rd_sh_head, rd_sp_next;
    logic [SHA-1:0] rd_it_shelf;
    logic           rd_it_live;
    logic [IPW-1:0] rd_it_fnext;

    assign rd_sh_top   = sh_rdata[DW-1:0];
    assign rd_sh_h     = sh_rdata[2*DW-1:DW];
    assign rd_sh_head  = sh_rdata[2*DW +: SPW];
    assign rd_sp_x     = sp_rdata[DW-1:0];
    assign rd_sp_w     = sp_rdata[2*DW-1:DW];
    assign rd_sp_next  = sp_rdata[2*DW +: SPW];
    assign rd_it_x     = it_rdata[DW-1:0];
    assign rd_it_w     = it_rdata[2*DW-1:DW];
    assign rd_it_shelf = it_rdata[2*DW +: SHA];
    assign rd_it_live  = it_rdata[2*DW+SHA];
    assign rd_it_fnext = it_rdata[2*DW+SHA+1 +: IPW];

    logic           item_avail, span_avail, jp, jn, split_span, new_has_span;
    logic [SHC-1:0] s_idx_inc;
    logic [DW-1:0]  rd_diff, sh_diff;
    logic [TW-1:0]  rd_shelf_end;
    logic [IA-1:0]  hd_idx;

    assign item_avail   = (item_free_head_reg != INIL)
                          || (item_used_reg < IPW'(MAX_ITEMS));
    assign span_avail   = (span_free_head_reg != SNIL)
                          || (span_used_reg < SPW'(MAX_SPANS));
    assign s_idx_inc    = s_idx_reg + SHC'(1);
    assign rd_diff      = rd_sh_h - h_reg;
    assign sh_diff      = sh_h_reg - h_reg;
    assign rd_shelf_end = TW'(rd_sh_top) + TW'(rd_sh_h);
    assign hd_idx       = IA'(hd_reg);
    assign split_span   = cur_w_reg > w_reg;
    assign new_has_span = w_reg < atlas_w;

    // A freed span joins the free span before it and/or the one after it.
    assign jp = (prev_reg != SNIL)
                && ((TW'(prev_x_reg) + TW'(prev_w_reg)) == TW'(ix_reg));
    assign jn = (cur_reg != SNIL)
                && ((TW'(ix_reg) + TW'(w_reg)) == TW'(cur_x_reg));

    function automatic sara_pkg::res_t make_res(sara_pkg::status_t st);
        sara_pkg::res_t r;
        r        = '0;
        r.status = st;
        return r;
    endfunction

    always_comb begin
        sh_we    = 1'b0;
        sh_waddr = is_reg;
        sh_wdata = {new_sp_reg, sh_h_reg, sh_top_reg};
        sp_we    = 1'b0;
        sp_waddr = cur_reg[SA-1:0];
        sp_wdata = {cur_next_reg, cur_w_reg, cur_x_reg};
        it_we    = 1'b0;
        it_waddr = it_idx_reg;
        it_wdata = {INIL, 1'b1, is_reg, w_reg, ix_reg};

        sh_raddr = (state_reg == S_RM_SHRD) ? is_reg : s_idx_reg[SHA-1:0];
        sp_raddr = (state_reg == S_TAKE_RD) ? span_free_head_reg[SA-1:0]
                                            : cur_reg[SA-1:0];
        it_raddr = (state_reg == S_ITEM_TAKE) ? item_free_head_reg[IA-1:0] : hd_idx;

        case (state_reg)
            S_NEW_WR: begin
                sh_we    = 1'b1;
                sh_waddr = shelf_count_reg[SHA-1:0];
                sh_wdata = {(new_has_span ? new_sp_reg : SNIL), h_reg,
                            top_max_reg[DW-1:0]};
                sp_we    = new_has_span;
                sp_waddr = new_sp_reg[SA-1:0];
                sp_wdata = {SNIL, DW'(atlas_w - w_reg), w_reg};
            end
            S_PLACE: begin
                if (split_span) begin
                    sp_we    = 1'b1;
                    sp_wdata = {cur_next_reg, DW'(cur_w_reg - w_reg),
                                DW'(cur_x_reg + w_reg)};
                end else if (prev_reg != SNIL) begin
                    sp_we    = 1'b1;
                    sp_waddr = prev_reg[SA-1:0];
                    sp_wdata = {cur_next_reg, prev_w_reg, prev_x_reg};
                end else begin
                    sh_we    = 1'b1;
                    sh_wdata = {cur_next_reg, sh_h_reg, sh_top_reg};
                end
            end
            S_PL_PUT, S_RM_PUT: begin
                sp_we    = 1'b1;
                sp_wdata = {span_free_head_reg, cur_w_reg, cur_x_reg};
            end
            S_ITEM_WR: begin
                it_we = 1'b1;
            end
            S_RM_MERGE: begin
                if (jp && jn) begin
                    sp_we    = 1'b1;
                    sp_waddr = prev_reg[SA-1:0];
                    sp_wdata = {cur_next_reg, DW'(prev_w_reg + w_reg + cur_w_reg),
                                prev_x_reg};
                end else if (jp) begin
                    sp_we    = 1'b1;
                    sp_waddr = prev_reg[SA-1:0];
                    sp_wdata = {prev_next_reg, DW'(prev_w_reg + w_reg), prev_x_reg};
                end else if (jn) begin
                    sp_we    = 1'b1;
                    sp_wdata = {cur_next_reg, DW'(cur_w_reg + w_reg), ix_reg};
                end
            end
            S_RM_NEW_WR: begin
                sp_we    = 1'b1;
                sp_waddr = new_sp_reg[SA-1:0];
                sp_wdata = {cur_reg, w_reg, ix_reg};
            end
            S_RM_LINK: begin
                if (prev_reg != SNIL) begin
                    sp_we    = 1'b1;
                    sp_waddr = prev_reg[SA-1:0];
                    sp_wdata = {new_sp_reg, prev_w_reg, prev_x_reg};
                end else begin
                    sh_we = 1'b1;
                end
            end
            S_RM_ITEM_WR: begin
                it_we    = 1'b1;
                it_waddr = hd_idx;
                it_wdata = {item_free_head_reg, 1'b0, is_reg, w_reg, ix_reg};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg          <= S_IDLE;
            shelf_count_reg    <= '0;
            span_free_head_reg <= SNIL;
            span_used_reg      <= '0;
            item_free_head_reg <= INIL;
            item_used_reg      <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (req_valid) begin
                        func_reg  <= req.func;
                        w_reg     <= req.rect_width;
                        h_reg     <= req.rect_height;
                        hd_reg    <= req.handle_in;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH: begin
                    case (func_reg)
                        sara_pkg::FN_ADD: begin
                            if (!item_avail) begin
                                res_reg   <= make_res(sara_pkg::ST_FULL);
                                state_reg <= S_EMIT;
                            end else begin
                                s_idx_reg      <= '0;
                                top_max_reg    <= '0;
                                best_valid_reg <= 1'b0;
                                place_mode_reg <= 1'b0;
                                state_reg <= (shelf_count_reg == '0) ? S_NEW_CHK : S_SH_RD;
                            end
                        end
                        sara_pkg::FN_REMOVE: begin
                            // Slots at or above the fill count were never handed out
                            // since the last clear, so they cannot be live.
                            if (32'(hd_reg) < 32'(item_used_reg)) begin
                                state_reg <= S_RM_ITEM;
                            end else begin
                                res_reg   <= make_res(sara_pkg::ST_BAD_HANDLE);
                                state_reg <= S_EMIT;
                            end
                        end
                        sara_pkg::FN_CLEAR: begin
                            shelf_count_reg    <= '0;
                            span_free_head_reg <= SNIL;
                            span_used_reg      <= '0;
                            item_free_head_reg <= INIL;
                            item_used_reg      <= '0;
                            res_reg            <= make_res(sara_pkg::ST_CLEARED);
                            state_reg          <= S_EMIT;
                        end
                        default: begin
                            res_reg   <= make_res(sara_pkg::ST_BAD_HANDLE);
                            state_reg <= S_EMIT;
                        end
                    endcase
                end
                S_SH_RD: begin
                    state_reg <= S_SH_CHK;
                end
                S_SH_CHK: begin
                    sh_top_reg <= rd_sh_top;
                    sh_h_reg   <= rd_sh_h;
                    cur_reg    <= rd_sh_head;
                    prev_reg   <= SNIL;
                    is_reg     <= s_idx_reg[SHA-1:0];
                    found_reg  <= 1'b0;
                    if (place_mode_reg) begin
                        state_reg <= S_WK_RD;
                    end else begin
                        if (rd_shelf_end > top_max_reg) begin
                            top_max_reg <= rd_shelf_end;
                        end
                        // Only walk a shelf that could still win.
                        if (rd_sh_h >= h_reg && (rd_sh_h == h_reg || !best_valid_reg
                                                 || rd_diff < best_score_reg)) begin
                            state_reg <= S_WK_RD;
                        end else if (s_idx_inc == shelf_count_reg) begin
                            state_reg <= S_SCAN_END;
                        end else begin
                            s_idx_reg <= s_idx_inc;
                            state_reg <= S_SH_RD;
                        end
                    end
                end
                S_WK_RD: begin
                    state_reg <= (cur_reg == SNIL) ? S_WK_END : S_WK_CHK;
                end
                S_WK_CHK: begin
                    if (rd_sp_w >= w_reg) begin
                        found_reg    <= 1'b1;
                        cur_x_reg    <= rd_sp_x;
                        cur_w_reg    <= rd_sp_w;
                        cur_next_reg <= rd_sp_next;
                        state_reg    <= S_WK_END;
                    end else begin
                        prev_reg   <= cur_reg;
                        prev_x_reg <= rd_sp_x;
                        prev_w_reg <= rd_sp_w;
                        cur_reg    <= rd_sp_next;
                        state_reg  <= S_WK_RD;
                    end
                end
                S_WK_END: begin
                    if (place_mode_reg) begin
                        if (found_reg) begin
                            state_reg <= S_PLACE;
                        end else begin
                            res_reg   <= make_res(sara_pkg::ST_NO_SPACE);
                            state_reg <= S_EMIT;
                        end
                    end else if (found_reg && sh_h_reg == h_reg) begin
                        state_reg <= S_PLACE;
                    end else begin
                        if (found_reg && (!best_valid_reg || sh_diff < best_score_reg)) begin
                            best_valid_reg <= 1'b1;
                            best_score_reg <= sh_diff;
                            best_s_reg     <= s_idx_reg;
                        end
                        if (s_idx_inc == shelf_count_reg) begin
                            state_reg <= S_SCAN_END;
                        end else begin
                            s_idx_reg <= s_idx_inc;
                            state_reg <= S_SH_RD;
                        end
                    end
                end
                S_SCAN_END: begin
                    if (best_valid_reg) begin
                        // Walk the best shelf again to recover its first fitting span.
                        place_mode_reg <= 1'b1;
                        s_idx_reg      <= best_s_reg;
                        state_reg      <= S_SH_RD;
                    end else begin
                        state_reg <= S_NEW_CHK;
                    end
                end
                S_NEW_CHK: begin
                    if (w_reg <= atlas_w && ((DW+2)'(top_max_reg) + (DW+2)'(h_reg))
                                            <= (DW+2)'(atlas_h)) begin
                        if (shelf_count_reg == SH_FULL || (new_has_span && !span_avail)) begin
                            res_reg   <= make_res(sara_pkg::ST_FULL);
                            state_reg <= S_EMIT;
                        end else if (new_has_span && span_free_head_reg != SNIL) begin
                            state_reg <= S_TAKE_RD;
                        end else begin
                            if (new_has_span) begin
                                new_sp_reg    <= span_used_reg;
                                span_used_reg <= span_used_reg + SPW'(1);
                            end
                            state_reg <= S_NEW_WR;
                        end
                    end else begin
                        res_reg   <= make_res(sara_pkg::ST_NO_SPACE);
                        state_reg <= S_EMIT;
                    end
                end
                S_TAKE_RD: begin
                    state_reg <= S_TAKE_DONE;
                end
                S_TAKE_DONE: begin
                    new_sp_reg         <= span_free_head_reg;
                    span_free_head_reg <= rd_sp_next;
                    state_reg <= (func_reg == sara_pkg::FN_ADD) ? S_NEW_WR : S_RM_NEW_WR;
                end
                S_NEW_WR: begin
                    shelf_count_reg <= shelf_count_reg + SHC'(1);
                    is_reg          <= shelf_count_reg[SHA-1:0];
                    ix_reg          <= '0;
                    place_top_reg   <= top_max_reg[DW-1:0];
                    state_reg       <= S_ITEM_TAKE;
                end
                S_PLACE: begin
                    ix_reg        <= cur_x_reg;
                    place_top_reg <= sh_top_reg;
                    state_reg     <= split_span ? S_ITEM_TAKE : S_PL_PUT;
                end
                S_PL_PUT: begin
                    span_free_head_reg <= cur_reg;
                    state_reg          <= S_ITEM_TAKE;
                end
                S_ITEM_TAKE: begin
                    if (item_free_head_reg != INIL) begin
                        state_reg <= S_ITEM_NEXT;
                    end else begin
                        it_idx_reg    <= item_used_reg[IA-1:0];
                        item_used_reg <= item_used_reg + IPW'(1);
                        state_reg     <= S_ITEM_WR;
                    end
                end
                S_ITEM_NEXT: begin
                    it_idx_reg         <= item_free_head_reg[IA-1:0];
                    item_free_head_reg <= rd_it_fnext;
                    state_reg          <= S_ITEM_WR;
                end
                S_ITEM_WR: begin
                    res_reg.status     <= sara_pkg::ST_PLACED;
                    res_reg.handle_out <= sara_pkg::HANDLE_W'(it_idx_reg);
                    res_reg.pos_x      <= ix_reg[sara_pkg::COORD_BITS-1:0];
                    res_reg.pos_y      <= place_top_reg[sara_pkg::COORD_BITS-1:0];
                    state_reg          <= S_EMIT;
                end
                S_RM_ITEM: begin
                    if (!rd_it_live) begin
                        res_reg   <= make_res(sara_pkg::ST_BAD_HANDLE);
                        state_reg <= S_EMIT;
                    end else begin
                        ix_reg    <= rd_it_x;
                        w_reg     <= rd_it_w;
                        is_reg    <= rd_it_shelf;
                        state_reg <= S_RM_SHRD;
                    end
                end
                S_RM_SHRD: begin
                    state_reg <= S_RM_SH;
                end
                S_RM_SH: begin
                    sh_top_reg <= rd_sh_top;
                    sh_h_reg   <= rd_sh_h;
                    cur_reg    <= rd_sh_head;
                    prev_reg   <= SNIL;
                    state_reg  <= S_RM_WK_RD;
                end
                S_RM_WK_RD: begin
                    state_reg <= (cur_reg == SNIL) ? S_RM_MERGE : S_RM_WK_CHK;
                end
                S_RM_WK_CHK: begin
                    cur_x_reg    <= rd_sp_x;
                    cur_w_reg    <= rd_sp_w;
                    cur_next_reg <= rd_sp_next;
                    if (ix_reg < rd_sp_x) begin
                        state_reg <= S_RM_MERGE;
                    end else begin
                        prev_reg      <= cur_reg;
                        prev_x_reg    <= rd_sp_x;
                        prev_w_reg    <= rd_sp_w;
                        prev_next_reg <= rd_sp_next;
                        cur_reg       <= rd_sp_next;
                        state_reg     <= S_RM_WK_RD;
                    end
                end
                S_RM_MERGE: begin
                    if (jp && jn) begin
                        state_reg <= S_RM_PUT;
                    end else if (jp || jn) begin
                        state_reg <= S_RM_ITEM_WR;
                    end else if (!span_avail) begin
                        res_reg   <= make_res(sara_pkg::ST_FULL);
                        state_reg <= S_EMIT;
                    end else if (span_free_head_reg != SNIL) begin
                        state_reg <= S_TAKE_RD;
                    end else begin
                        new_sp_reg    <= span_used_reg;
                        span_used_reg <= span_used_reg + SPW'(1);
                        state_reg     <= S_RM_NEW_WR;
                    end
                end
                S_RM_PUT: begin
                    span_free_head_reg <= cur_reg;
                    state_reg          <= S_RM_ITEM_WR;
                end
                S_RM_NEW_WR: begin
                    state_reg <= S_RM_LINK;
                end
                S_RM_LINK: begin
                    state_reg <= S_RM_ITEM_WR;
                end
                S_RM_ITEM_WR: begin
                    item_free_head_reg <= IPW'(hd_reg);
                    res_reg            <= make_res(sara_pkg::ST_REMOVED);
                    state_reg          <= S_EMIT;
                end
                S_EMIT: begin
                    if (res_ready) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

endmodule

`default_nettype wire

// ===== rtl/shelf_atlas_rect_allocator.sv =====
// Add scans the shelves and walks the spans of each candidate shelf, plus one
// more pass over the best shelf when no exact-height shelf fits. Remove walks the
// spans of its shelf up to the item; clear resets fill counts and free list heads.
// One request is in flight at a time; the span walk through the span RAM sets the pace.
// Reset is synchronous, active low, and empties every store at once through the fill
// counts and free list heads; the RAMs themselves are not swept.
// ============================================================================
// shelf_atlas_rect_allocator: shelf packing allocator for a 2D atlas
// Config registers, request intake and the result output register.
// ============================================================================
`default_nettype none

module shelf_atlas_rect_allocator #(
    parameter int MAX_SHELVES = 64,
    parameter int MAX_SPANS   = 1024,
    parameter int MAX_ITEMS   = 1024
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // rect_width[12:0], rect_height[25:13], handle_in[35:26], zero fill
    input  wire logic [sara_pkg::S_TDATA_W-1:0]    s_tdata,
    // func[1:0]
    input  wire logic [sara_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // handle_out[9:0], pos_x[21:10], pos_y[33:22], zero fill
    output logic [sara_pkg::M_TDATA_W-1:0]         m_tdata,
    // status[2:0]
    output logic [sara_pkg::M_TUSER_W-1:0]         m_tuser,
    input  wire logic                              cfg_wr_en,
    input  wire logic [sara_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [sara_pkg::DIM_W-1:0]        cfg_wr_data
);

    localparam int DW  = sara_pkg::DIM_W;
    localparam int HW  = sara_pkg::HANDLE_W;
    localparam int CB  = sara_pkg::COORD_BITS;
    localparam int PAD = sara_pkg::M_TDATA_W - HW - 2 * CB;

    logic [DW-1:0] atlas_width_reg, atlas_height_reg;
    logic [DW-1:0] eff_w, eff_h;

    logic                             m_valid_reg;
    logic [sara_pkg::M_TDATA_W-1:0]   m_data_reg;
    logic [sara_pkg::M_TUSER_W-1:0]   m_user_reg;

    sara_pkg::req_t req;
    sara_pkg::res_t res;
    logic           res_valid, res_ready;

    // Zero selects the default size, anything past the largest atlas is clamped.
    function automatic logic [DW-1:0] eff_dim(input logic [DW-1:0] r);
        if (r == '0) begin
            return sara_pkg::DIM_DEFAULT;
        end else if (r > sara_pkg::DIM_MAX) begin
            return sara_pkg::DIM_MAX;
        end
        return r;
    endfunction

    assign eff_w = eff_dim(atlas_width_reg);
    assign eff_h = eff_dim(atlas_height_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            atlas_width_reg  <= sara_pkg::DIM_DEFAULT;
            atlas_height_reg <= sara_pkg::DIM_DEFAULT;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sara_pkg::CFG_ATLAS_WIDTH:  atlas_width_reg  <= cfg_wr_data;
                sara_pkg::CFG_ATLAS_HEIGHT: atlas_height_reg <= cfg_wr_data;
                default: begin
                end
            endcase
        end
    end

    assign req.func        = s_tuser;
    assign req.rect_width  = s_tdata[DW-1:0];
    assign req.rect_height = s_tdata[2*DW-1:DW];
    assign req.handle_in   = s_tdata[2*DW +: HW];

    sara_core #(
        .MAX_SHELVES(MAX_SHELVES),
        .MAX_SPANS  (MAX_SPANS),
        .MAX_ITEMS  (MAX_ITEMS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req_valid(s_tvalid),
        .req_ready(s_tready),
        .req      (req),
        .atlas_w  (eff_w),
        .atlas_h  (eff_h),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= {PAD'(0), res.pos_y, res.pos_x, res.handle_out};
            m_user_reg  <= res.status;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ===== rtl/sara_checker.sv =====
// ============================================================================
// sara_checker: port-level checks for the shelf atlas allocator
// Watches the request and result channels and is bound to the top level.
// ============================================================================
`default_nettype none

module sara_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_tvalid,
    input wire logic                              s_tready,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [sara_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic [sara_pkg::M_TUSER_W-1:0]    m_tuser
);

    // Only one request is worked on at a time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another one is in progress");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= sara_pkg::M_TUSER_W'(sara_pkg::ST_FULL))
        else $error("result carries an undefined status");

    // Only a placed rectangle carries a handle and a position.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != sara_pkg::M_TUSER_W'(sara_pkg::ST_PLACED) |-> m_tdata == '0)
        else $error("non-placement result carries payload");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

bind shelf_atlas_rect_allocator sara_checker u_checker (.*);

`default_nettype wire

// ===== tb/sv/atlas_alloc_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// atlas_alloc_checker: result checker for the shelf atlas allocator
// Watches the request, result and register ports, keeps its own copy of the
// shelf, span and item stores, predicts each result and compares it field by
// field with what the allocator returns.
// ============================================================================
`default_nettype none

module atlas_alloc_checker
    import sara_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    input  wire logic                   s_tready,
    input  wire logic [S_TDATA_W-1:0]   s_tdata,
    input  wire logic [S_TUSER_W-1:0]   s_tuser,
    input  wire logic                   m_tvalid,
    input  wire logic                   m_tready,
    input  wire logic [M_TDATA_W-1:0]   m_tdata,
    input  wire logic [M_TUSER_W-1:0]   m_tuser,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [DIM_W-1:0]       cfg_wr_data,
    output int                          pending,
    output int                          fail_count,
    output int                          results_seen
);

    localparam int unsigned N_SHELF = 64;
    localparam int unsigned N_SPAN  = 1024;
    localparam int unsigned N_ITEM  = 1024;
    localparam int unsigned SP_NIL  = N_SPAN;
    localparam int unsigned IT_NIL  = N_ITEM;
    localparam int unsigned SH_NIL  = N_SHELF;
    localparam int unsigned NO_SCORE = 32'h7fffffff;

    logic [DIM_W-1:0] reg_width, reg_height;

    int unsigned n_shelves;
    int unsigned sh_top [N_SHELF];
    int unsigned sh_hgt [N_SHELF];
    int unsigned sh_head[N_SHELF];
    int unsigned sp_x   [N_SPAN];
    int unsigned sp_w   [N_SPAN];
    int unsigned sp_nxt [N_SPAN];
    int unsigned sp_free, sp_cnt;
    int unsigned it_x   [N_ITEM];
    int unsigned it_w   [N_ITEM];
    int unsigned it_sh  [N_ITEM];
    bit          it_live[N_ITEM];
    int unsigned it_nxt [N_ITEM];
    int unsigned it_free, it_cnt;

    res_t placement_q[$];

    function automatic void wipe_stores();
        n_shelves = 0;
        sp_free = SP_NIL;
        sp_cnt = 0;
        it_free = IT_NIL;
        it_cnt = 0;
        foreach (it_live[i]) it_live[i] = 1'b0;
    endfunction

    function automatic int unsigned eff_dim(logic [DIM_W-1:0] r);
        if (r == '0) return DIM_DEFAULT;
        if (r > DIM_MAX) return DIM_MAX;
        return r;
    endfunction

    function automatic res_t make_res(status_t st, int unsigned hd, int unsigned x,
                                      int unsigned y);
        res_t r;
        r.status = st;
        r.handle_out = hd[HANDLE_W-1:0];
        r.pos_x = x[COORD_BITS-1:0];
        r.pos_y = y[COORD_BITS-1:0];
        return r;
    endfunction

    function automatic bit span_free_slot();
        return sp_free < SP_NIL || sp_cnt < N_SPAN;
    endfunction

    function automatic int unsigned span_alloc();
        int unsigned i;
        if (sp_free < SP_NIL) begin
            i = sp_free;
            sp_free = sp_nxt[i];
            return i;
        end
        sp_cnt++;
        return sp_cnt - 1;
    endfunction

    function automatic void span_release(int unsigned i);
        sp_nxt[i] = sp_free;
        sp_free = i;
    endfunction

    // First span of a shelf at least w wide; prev gets the span before it.
    function automatic int unsigned first_fit(int unsigned s, int unsigned w,
                                              output int unsigned prev);
        int unsigned cur;
        cur = sh_head[s];
        prev = SP_NIL;
        while (cur < SP_NIL && sp_w[cur] < w) begin
            prev = cur;
            cur = sp_nxt[cur];
        end
        return cur;
    endfunction

    function automatic int unsigned claim_item(int unsigned s, int unsigned x,
                                               int unsigned w);
        int unsigned it;
        if (it_free < IT_NIL) begin
            it = it_free;
            it_free = it_nxt[it];
        end else begin
            it = it_cnt;
            it_cnt++;
        end
        it_x[it] = x;
        it_w[it] = w;
        it_sh[it] = s;
        it_live[it] = 1'b1;
        it_nxt[it] = IT_NIL;
        return it;
    endfunction

    function automatic res_t place_on_shelf(int unsigned s, int unsigned w);
        int unsigned prev, sp, x, it;
        sp = first_fit(s, w, prev);
        x = sp_x[sp];
        if (sp_w[sp] > w) begin
            sp_x[sp] += w;
            sp_w[sp] -= w;
        end else begin
            if (prev < SP_NIL) sp_nxt[prev] = sp_nxt[sp];
            else sh_head[s] = sp_nxt[sp];
            span_release(sp);
        end
        it = claim_item(s, x, w);
        return make_res(ST_PLACED, it, x, sh_top[s]);
    endfunction

    function automatic res_t add_rect(int unsigned w, int unsigned h);
        int unsigned best, score, top, prev, aw, ah, s, sp, it, t;
        bit fits;
        best = SH_NIL;
        score = NO_SCORE;
        top = 0;
        aw = eff_dim(reg_width);
        ah = eff_dim(reg_height);
        if (!(it_free < IT_NIL || it_cnt < N_ITEM)) return make_res(ST_FULL, 0, 0, 0);
        for (s = 0; s < n_shelves; s++) begin
            t = sh_top[s] + sh_hgt[s];
            if (t > top) top = t;
            if (sh_hgt[s] < h) continue;
            fits = first_fit(s, w, prev) < SP_NIL;
            if (sh_hgt[s] == h && fits) return place_on_shelf(s, w);
            if (sh_hgt[s] - h < score && fits) begin
                score = sh_hgt[s] - h;
                best = s;
            end
        end
        if (best < SH_NIL) return place_on_shelf(best, w);
        if (w <= aw && top + h <= ah) begin
            if (n_shelves >= N_SHELF || (w < aw && !span_free_slot()))
                return make_res(ST_FULL, 0, 0, 0);
            s = n_shelves;
            n_shelves++;
            sh_top[s] = top;
            sh_hgt[s] = h;
            sh_head[s] = SP_NIL;
            if (w < aw) begin
                sp = span_alloc();
                sp_x[sp] = w;
                sp_w[sp] = aw - w;
                sp_nxt[sp] = SP_NIL;
                sh_head[s] = sp;
            end
            it = claim_item(s, 0, w);
            return make_res(ST_PLACED, it, 0, top);
        end
        return make_res(ST_NO_SPACE, 0, 0, 0);
    endfunction

    function automatic res_t remove_rect(int unsigned hd);
        int unsigned s, x, w, prev, cur, n;
        bit join_l, join_r;
        if (!it_live[hd]) return make_res(ST_BAD_HANDLE, 0, 0, 0);
        s = it_sh[hd];
        x = it_x[hd];
        w = it_w[hd];
        prev = SP_NIL;
        cur = sh_head[s];
        while (cur < SP_NIL && !(x < sp_x[cur])) begin
            prev = cur;
            cur = sp_nxt[cur];
        end
        join_l = prev < SP_NIL && sp_x[prev] + sp_w[prev] == x;
        join_r = cur < SP_NIL && x + w == sp_x[cur];
        if (join_l) begin
            sp_w[prev] += w;
            if (join_r) begin
                sp_w[prev] += sp_w[cur];
                sp_nxt[prev] = sp_nxt[cur];
                span_release(cur);
            end
        end else if (join_r) begin
            sp_x[cur] = x;
            sp_w[cur] += w;
        end else begin
            if (!span_free_slot()) return make_res(ST_FULL, 0, 0, 0);
            n = span_alloc();
            sp_x[n] = x;
            sp_w[n] = w;
            sp_nxt[n] = cur;
            if (prev < SP_NIL) sp_nxt[prev] = n;
            else sh_head[s] = n;
        end
        it_live[hd] = 1'b0;
        it_nxt[hd] = it_free;
        it_free = hd;
        return make_res(ST_REMOVED, 0, 0, 0);
    endfunction

    function automatic res_t alloc_predict(logic [FUNC_W-1:0] fn, req_t rq);
        case (fn)
            FN_ADD:    return add_rect(rq.rect_width, rq.rect_height);
            FN_REMOVE: return remove_rect(rq.handle_in);
            FN_CLEAR: begin
                wipe_stores();
                return make_res(ST_CLEARED, 0, 0, 0);
            end
            default:   return make_res(ST_BAD_HANDLE, 0, 0, 0);
        endcase
    endfunction

    function automatic void report_mismatch(string what, res_t exp_r, res_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t mismatch (%s): expected st=%0d h=%0d x=%0d y=%0d, got st=%0d h=%0d x=%0d y=%0d",
                     $time, what, exp_r.status, exp_r.handle_out, exp_r.pos_x, exp_r.pos_y,
                     got.status, got.handle_out, got.pos_x, got.pos_y);
    endfunction

    initial begin
        fail_count = 0;
        results_seen = 0;
        reg_width = DIM_DEFAULT;
        reg_height = DIM_DEFAULT;
        wipe_stores();
    end

    assign pending = placement_q.size();

    always @(posedge aclk) begin
        req_t rq;
        res_t got, exp_r;
        if (!aresetn) begin
            reg_width <= DIM_DEFAULT;
            reg_height <= DIM_DEFAULT;
            wipe_stores();
            placement_q.delete();
        end else begin
            if (cfg_wr_en) begin
                if (cfg_index == CFG_ATLAS_WIDTH) reg_width <= cfg_wr_data;
                else reg_height <= cfg_wr_data;
            end
            if (s_tvalid && s_tready) begin
                rq.func = s_tuser;
                rq.rect_width = s_tdata[12:0];
                rq.rect_height = s_tdata[25:13];
                rq.handle_in = s_tdata[35:26];
                placement_q.push_back(alloc_predict(s_tuser, rq));
            end
            if (m_tvalid && m_tready) begin
                got.status = status_t'(m_tuser);
                got.handle_out = m_tdata[9:0];
                got.pos_x = m_tdata[21:10];
                got.pos_y = m_tdata[33:22];
                results_seen++;
                if (placement_q.size() == 0) begin
                    report_mismatch("no request outstanding", got, got);
                end else begin
                    exp_r = placement_q.pop_front();
                    if (got != exp_r) report_mismatch("field", exp_r, got);
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/shelf_atlas_rect_allocator_tb.sv =====
`timescale 1ns / 100ps
// ============================================================================
// shelf_atlas_rect_allocator_tb: top-level testbench of the atlas allocator
// Drives add, remove, clear and bad function requests over several atlas sizes, with
// random gaps and result stalls; a checker beside the block predicts results.
// ============================================================================
`default_nettype none

module shelf_atlas_rect_allocator_tb;
    import sara_pkg::*;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_ATLAS_WIDTH;
    logic [DIM_W-1:0]     cfg_wr_data = '0;

    int pending, fail_count, results_seen;
    int requests_sent = 0;
    int cyc = 0;
    bit steady_input = 1'b0;
    int stall_left = 0;
    int unsigned eff_w = 64, eff_h = 64;

    always #5 aclk = ~aclk;

    shelf_atlas_rect_allocator u_top (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .cfg_wr_en, .cfg_index, .cfg_wr_data
    );

    atlas_alloc_checker u_chk (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .m_tuser, .cfg_wr_en, .cfg_index, .cfg_wr_data,
        .pending, .fail_count, .results_seen
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result stalls, with a recurring quiet window where m_tready stays high.
    always @(negedge aclk) begin
        cyc <= cyc + 1;
        if (cyc % 1000 < 150) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            stall_left <= gap_len();
        end
    end

    task automatic send_req(func_t fn, int unsigned w, int unsigned h, int unsigned hd);
        int g;
        g = steady_input ? 0 : gap_len();
        repeat (g) @(negedge aclk);
        s_tuser = fn;
        s_tdata = '0;
        s_tdata[12:0] = w[12:0];
        s_tdata[25:13] = h[12:0];
        s_tdata[35:26] = hd[9:0];
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        requests_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic set_atlas(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
        while (pending != 0) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = CFG_ATLAS_WIDTH;
        cfg_wr_data = w;
        @(negedge aclk);
        cfg_index = CFG_ATLAS_HEIGHT;
        cfg_wr_data = h;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        eff_w = (w == 0) ? 64 : (w > 4096) ? 4096 : w;
        eff_h = (h == 0) ? 64 : (h > 4096) ? 4096 : h;
    endtask

    function automatic int unsigned pick_dim(int unsigned lim);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(0, lim / 4 + 1);
        if (r < 85) return $urandom_range(0, lim);
        if (r < 95) return lim;
        return $urandom_range(0, 4096);
    endfunction

    task automatic random_req();
        int r;
        int unsigned h;
        r = $urandom_range(0, 99);
        if (r < 58) begin
            h = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 4) : pick_dim(eff_h);
            send_req(FN_ADD, pick_dim(eff_w), h, $urandom_range(0, 1023));
        end else if (r < 96) begin
            send_req(FN_REMOVE, $urandom_range(0, 4096), $urandom_range(0, 4096),
                     ($urandom_range(0, 4) != 0) ? $urandom_range(0, 63)
                                                 : $urandom_range(0, 1023));
        end else if (r < 98) begin
            send_req(FN_CLEAR, $urandom_range(0, 4096), $urandom_range(0, 4096),
                     $urandom_range(0, 1023));
        end else begin
            send_req(func_t'(2'd3), 0, 0, $urandom_range(0, 1023));
        end
    endtask

    initial begin
        logic [DIM_W-1:0] cfg_w [6] = '{13'd64, 13'd1, 13'd0, 13'd300, 13'd4096, 13'd37};
        logic [DIM_W-1:0] cfg_h [6] = '{13'd64, 13'd1, 13'd8191, 13'd120, 13'd4096, 13'd4095};
        int counts [6] = '{220, 90, 110, 160, 150, 130};
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: default 64 x 64 atlas.
        send_req(FN_ADD, 0, 0, 0);          // zero-height shelf at the bottom
        send_req(FN_ADD, 64, 64, 0);        // fills the whole width, no remainder span
        send_req(FN_ADD, 10, 5, 0);         // out of room
        send_req(FN_REMOVE, 0, 0, 1);
        send_req(FN_REMOVE, 0, 0, 1);       // already removed
        send_req(FN_REMOVE, 0, 0, 1023);    // never given
        send_req(func_t'(2'd3), 8191, 8191, 1023);
        send_req(FN_CLEAR, 0, 0, 0);
        send_req(FN_REMOVE, 0, 0, 0);       // cleared handle
        send_req(FN_ADD, 4096, 4096, 0);
        send_req(FN_ADD, 8, 8, 0);
        send_req(FN_ADD, 8, 8, 0);          // exact height
        send_req(FN_ADD, 8, 4, 0);          // best fit in a taller shelf
        send_req(FN_ADD, 16, 16, 0);
        send_req(FN_REMOVE, 0, 0, 1);       // no neighbor, new span
        send_req(FN_REMOVE, 0, 0, 0);       // joins the right neighbor span
        send_req(FN_REMOVE, 0, 0, 2);       // joins both sides

        set_atlas(13'd4096, 13'd4096);
        send_req(FN_CLEAR, 0, 0, 0);
        send_req(FN_ADD, 4096, 4096, 0);
        send_req(FN_ADD, 0, 0, 0);          // zero-height shelf at y = 4096 reads as 0

        // Fill the item store with tiny rectangles and keep adding past its capacity.
        send_req(FN_CLEAR, 0, 0, 0);
        steady_input = 1'b1;
        repeat (1030) send_req(FN_ADD, $urandom_range(0, 3), $urandom_range(0, 1),
                               $urandom_range(0, 1023));
        steady_input = 1'b0;

        // Exhaust the shelf store with full-width shelves of growing height.
        set_atlas(13'd16, 13'd4096);
        send_req(FN_CLEAR, 0, 0, 0);
        for (int k = 1; k <= 66; k++) send_req(FN_ADD, 16, k, 0);

        for (int p = 0; p < 6; p++) begin
            set_atlas(cfg_w[p], cfg_h[p]);
            if (p % 2 == 1) send_req(FN_CLEAR, 0, 0, 0);
            steady_input = (p == 3);
            repeat (counts[p]) random_req();
        end
        steady_input = 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
        $display("Sent %0d requests over seven distinct atlas sizes, checked %0d results.",
                 requests_sent, results_seen);
        $display("Covered exact and best-fit placement, span merges, full stores and bad handles.");
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #1s;
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== shelf_atlas_rect_allocator.f =====
rtl/sara_pkg.sv
rtl/sara_ram.sv
rtl/sara_core.sv
rtl/shelf_atlas_rect_allocator.sv
rtl/sara_checker.sv
tb/sv/atlas_alloc_checker.sv
tb/sv/shelf_atlas_rect_allocator_tb.sv
